@@ rtl/core/rc4sc_pkg.sv @@
// Shared types and constants for the RC4 stream cipher core.
// Holds the microcode word layout, the step program and register codes.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none

package rc4sc_pkg;

  // Payload widths fixed by the item format.
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int KEY_LEN_W   = 5;
  localparam int PERM_DEPTH  = 256;
  localparam int BYTES_PER_WORD = CFG_DATA_W / BYTE_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

  // Microcode step addresses.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] ST_IDLE = 4'd0;
  localparam logic [UPC_W-1:0] ST_INIT = 4'd1;
  localparam logic [UPC_W-1:0] ST_KA   = 4'd2;
  localparam logic [UPC_W-1:0] ST_KB   = 4'd3;
  localparam logic [UPC_W-1:0] ST_KC   = 4'd4;
  localparam logic [UPC_W-1:0] ST_KD   = 4'd5;
  localparam logic [UPC_W-1:0] ST_KEND = 4'd6;
  localparam logic [UPC_W-1:0] ST_PA   = 4'd7;
  localparam logic [UPC_W-1:0] ST_PB   = 4'd8;
  localparam logic [UPC_W-1:0] ST_PC   = 4'd9;
  localparam logic [UPC_W-1:0] ST_PD   = 4'd10;

  // Read address source of the permutation memory.
  typedef enum logic [2:0] {
    RD_NONE, RD_A, RD_JNXT, RD_INXT, RD_T
  } rd_sel_t;

  // Write address and data source of the permutation memory.
  typedef enum logic [2:0] {
    WR_NONE, WR_INIT, WR_A_RD, WR_J_SI, WR_I_RD
  } wr_sel_t;

  typedef enum logic [1:0] {J_HOLD, J_CLEAR, J_KSA, J_PRGA} j_op_t;
  typedef enum logic [1:0] {I_HOLD, I_CLEAR, I_INC} i_op_t;
  typedef enum logic [1:0] {A_HOLD, A_INC_INIT, A_INC_KSA} a_op_t;

  // Sequencing: how the next step address is chosen.
  typedef enum logic [2:0] {
    SEQ_NEXT, SEQ_GOTO, SEQ_DISPATCH, SEQ_LOOP, SEQ_OUT
  } seq_t;

  typedef struct packed {
    logic             in_rdy;
    rd_sel_t          rd_sel;
    wr_sel_t          wr_sel;
    j_op_t            j_op;
    i_op_t            i_op;
    a_op_t            a_op;
    logic             cap_si;
    logic             cap_sj;
    logic             set_keyed;
    logic             out_load;
    seq_t             seq;
    logic [UPC_W-1:0] tgt_a;
    logic [UPC_W-1:0] tgt_b;
  } ctrl_word_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic need_ksa;
    logic a_last;
    logic out_free;
  } ctrl_status_t;

  // The microprogram. Unused addresses return to idle.
  function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] pc);
    ctrl_word_t w;
    w = '{in_rdy: 1'b0, rd_sel: RD_NONE, wr_sel: WR_NONE, j_op: J_HOLD,
          i_op: I_HOLD, a_op: A_HOLD, cap_si: 1'b0, cap_sj: 1'b0,
          set_keyed: 1'b0, out_load: 1'b0, seq: SEQ_GOTO,
          tgt_a: ST_IDLE, tgt_b: ST_IDLE};
    case (pc)
      // Wait for an item, then key or go straight to the keystream.
      ST_IDLE: begin
        w.in_rdy = 1'b1;
        w.seq    = SEQ_DISPATCH;
        w.tgt_a  = ST_INIT;
        w.tgt_b  = ST_PA;
      end
      // Identity fill, one entry per step.
      ST_INIT: begin
        w.wr_sel = WR_INIT;
        w.a_op   = A_INC_INIT;
        w.j_op   = J_CLEAR;
        w.seq    = SEQ_LOOP;
        w.tgt_a  = ST_INIT;
        w.tgt_b  = ST_KA;
      end
      // Key schedule: read S[a].
      ST_KA: begin
        w.rd_sel = RD_A;
        w.seq    = SEQ_NEXT;
      end
      // Add S[a] and key byte into j, read S[j].
      ST_KB: begin
        w.j_op   = J_KSA;
        w.rd_sel = RD_JNXT;
        w.cap_si = 1'b1;
        w.seq    = SEQ_NEXT;
      end
      // S[a] takes the old S[j].
      ST_KC: begin
        w.wr_sel = WR_A_RD;
        w.seq    = SEQ_NEXT;
      end
      // S[j] takes the old S[a]; advance a and the key index.
      ST_KD: begin
        w.wr_sel = WR_J_SI;
        w.a_op   = A_INC_KSA;
        w.seq    = SEQ_LOOP;
        w.tgt_a  = ST_KA;
        w.tgt_b  = ST_KEND;
      end
      ST_KEND: begin
        w.i_op      = I_CLEAR;
        w.j_op      = J_CLEAR;
        w.set_keyed = 1'b1;
        w.seq       = SEQ_NEXT;
      end
      // Keystream: advance i, read S[i].
      ST_PA: begin
        w.i_op   = I_INC;
        w.rd_sel = RD_INXT;
        w.seq    = SEQ_NEXT;
      end
      // Add S[i] into j, read S[j].
      ST_PB: begin
        w.j_op   = J_PRGA;
        w.rd_sel = RD_JNXT;
        w.cap_si = 1'b1;
        w.seq    = SEQ_NEXT;
      end
      // S[i] takes S[j]; read S[S[i]+S[j]] from the pre-swap contents.
      ST_PC: begin
        w.wr_sel = WR_I_RD;
        w.rd_sel = RD_T;
        w.cap_sj = 1'b1;
        w.seq    = SEQ_NEXT;
      end
      // S[j] takes S[i]; hand the result over once the output is free.
      ST_PD: begin
        w.wr_sel   = WR_J_SI;
        w.out_load = 1'b1;
        w.seq      = SEQ_OUT;
        w.tgt_a    = ST_IDLE;
      end
      default: begin
        w.seq   = SEQ_GOTO;
        w.tgt_a = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rc4sc_if.sv @@
// Valid/ready channel interfaces of the RC4 cipher core: data input,
// data output and configuration write. Depends on rc4sc_pkg for widths.
`default_nettype none

interface rc4sc_in_if;
  logic                           valid;
  logic                           ready;
  logic [rc4sc_pkg::BYTE_W-1:0]   data_in;
  logic                           message_start;
  modport source (output valid, output data_in, output message_start, input ready);
  modport sink   (input valid, input data_in, input message_start, output ready);
endinterface

interface rc4sc_out_if;
  logic                           valid;
  logic                           ready;
  logic [rc4sc_pkg::BYTE_W-1:0]   data_out;
  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

interface rc4sc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rc4sc_pkg::CFG_IDX_W-1:0]    index;
  logic [rc4sc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rc4sc_ctrl.sv @@
// Microcode sequencer of the RC4 cipher core: step counter, program ROM
// and conditional jumps. Depends on rc4sc_pkg.
`default_nettype none

module rc4sc_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  rc4sc_pkg::ctrl_status_t  status,
  output rc4sc_pkg::ctrl_word_t    ctrl
);

  logic [rc4sc_pkg::UPC_W-1:0] upc_r;
  logic [rc4sc_pkg::UPC_W-1:0] upc_nxt;

  // Current control word straight from the program table.
  assign ctrl = rc4sc_pkg::ucode_rom(upc_r);

  // Next step address.
  always_comb begin
    unique case (ctrl.seq)
      rc4sc_pkg::SEQ_NEXT:     upc_nxt = upc_r + 1'b1;
      rc4sc_pkg::SEQ_GOTO:     upc_nxt = ctrl.tgt_a;
      rc4sc_pkg::SEQ_DISPATCH: begin
        if (!status.in_valid) begin
          upc_nxt = upc_r;
        end else if (status.need_ksa) begin
          upc_nxt = ctrl.tgt_a;
        end else begin
          upc_nxt = ctrl.tgt_b;
        end
      end
      rc4sc_pkg::SEQ_LOOP:     upc_nxt = status.a_last ? ctrl.tgt_b : ctrl.tgt_a;
      rc4sc_pkg::SEQ_OUT:      upc_nxt = status.out_free ? ctrl.tgt_a : upc_r;
      default:                 upc_nxt = rc4sc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= rc4sc_pkg::ST_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rc4_stream_cipher.sv @@
// RC4 stream cipher core: one byte in, the byte XORed with keystream out.
// Keyed item: 4 memory steps a byte on the 256x8 permutation memory (one
// read and one write port); a new item is taken only once the last one's result
// is handed to the output. A message start (or the first item after reset) adds
// the key schedule: 256 identity writes plus 4 memory steps per entry.
// Reset clears indices, sequencer, key registers and the keyed flag.
`default_nettype none

module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  wire             clk,
  input  wire             rst_n,
  rc4sc_in_if.sink        in_chan,
  rc4sc_out_if.source     out_chan,
  rc4sc_cfg_if.sink       cfg_chan
);

  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int BW = rc4sc_pkg::BYTE_W;

  rc4sc_pkg::ctrl_word_t   ctrl;
  rc4sc_pkg::ctrl_status_t status;

  // Key and configuration registers.
  logic [BW-1:0]                     key_r [MAX_KEY_BYTES];
  logic [rc4sc_pkg::KEY_LEN_W-1:0]   key_len_r;
  logic [rc4sc_pkg::KEY_LEN_W-1:0]   eff_len;
  logic                              cfg_fire;

  // Datapath state.
  logic [BW-1:0] perm_mem [rc4sc_pkg::PERM_DEPTH];
  logic [BW-1:0] rd_data_r;
  logic [BW-1:0] i_r, i_nxt, j_r, j_nxt, a_r, si_r, sj_r, t_r;
  logic [KW-1:0] k_r;
  logic          k_last;
  logic          keyed_r;
  logic [BW-1:0] data_r;
  logic [BW-1:0] out_data_r;
  logic          out_valid_r;
  logic          in_fire;
  logic          out_free;
  logic [BW-1:0] key_cur;
  logic [BW-1:0] t_addr;
  logic [BW-1:0] ks;
  logic          rd_en, wr_en;
  logic [BW-1:0] rd_addr, wr_addr, wr_data;

  rc4sc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  // Handshakes.
  assign in_chan.ready  = ctrl.in_rdy;
  assign in_fire        = in_chan.valid & ctrl.in_rdy;
  assign cfg_chan.ready = 1'b1;
  assign cfg_fire       = cfg_chan.valid;
  assign out_free       = !out_valid_r || out_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.data_out = out_data_r;

  assign status.in_valid = in_chan.valid;
  assign status.need_ksa = in_chan.message_start | ~keyed_r;
  assign status.a_last   = (a_r == {BW{1'b1}});
  assign status.out_free = out_free;

  // Key bytes beyond the supported length are not stored.
  for (genvar b = 0; b < MAX_KEY_BYTES; b++) begin : g_key
    localparam logic [rc4sc_pkg::CFG_IDX_W-1:0] WORD_IDX =
      (b < rc4sc_pkg::BYTES_PER_WORD) ? rc4sc_pkg::REG_KEY_LOW : rc4sc_pkg::REG_KEY_HIGH;
    localparam int LSB = (b % rc4sc_pkg::BYTES_PER_WORD) * BW;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        key_r[b] <= '0;
      end else if (cfg_fire && cfg_chan.index == WORD_IDX) begin
        key_r[b] <= cfg_chan.data[LSB +: BW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= rc4sc_pkg::KEY_LEN_RESET;
    end else if (cfg_fire && cfg_chan.index == rc4sc_pkg::REG_KEY_LEN) begin
      key_len_r <= cfg_chan.data[rc4sc_pkg::KEY_LEN_W-1:0];
    end
  end

  // Zero length acts as one byte; lengths above the maximum saturate.
  always_comb begin
    if (key_len_r == '0) begin
      eff_len = rc4sc_pkg::KEY_LEN_W'(1);
    end else if (key_len_r > rc4sc_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) begin
      eff_len = rc4sc_pkg::KEY_LEN_W'(MAX_KEY_BYTES);
    end else begin
      eff_len = key_len_r;
    end
  end

  assign key_cur = key_r[k_r];
  assign k_last  = (rc4sc_pkg::KEY_LEN_W'(k_r) == eff_len - rc4sc_pkg::KEY_LEN_W'(1));

  // Index updates.
  always_comb begin
    unique case (ctrl.j_op)
      rc4sc_pkg::J_CLEAR: j_nxt = '0;
      rc4sc_pkg::J_KSA:   j_nxt = j_r + rd_data_r + key_cur;
      rc4sc_pkg::J_PRGA:  j_nxt = j_r + rd_data_r;
      default:            j_nxt = j_r;
    endcase
    unique case (ctrl.i_op)
      rc4sc_pkg::I_CLEAR: i_nxt = '0;
      rc4sc_pkg::I_INC:   i_nxt = i_r + 1'b1;
      default:            i_nxt = i_r;
    endcase
  end

  assign t_addr = rd_data_r + si_r;

  // Memory read port selection.
  always_comb begin
    rd_en = 1'b1;
    unique case (ctrl.rd_sel)
      rc4sc_pkg::RD_A:    rd_addr = a_r;
      rc4sc_pkg::RD_JNXT: rd_addr = j_nxt;
      rc4sc_pkg::RD_INXT: rd_addr = i_nxt;
      rc4sc_pkg::RD_T:    rd_addr = t_addr;
      default: begin
        rd_en   = 1'b0;
        rd_addr = a_r;
      end
    endcase
  end

  // Memory write port selection.
  always_comb begin
    wr_en = 1'b1;
    unique case (ctrl.wr_sel)
      rc4sc_pkg::WR_INIT: begin
        wr_addr = a_r;
        wr_data = a_r;
      end
      rc4sc_pkg::WR_A_RD: begin
        wr_addr = a_r;
        wr_data = rd_data_r;
      end
      rc4sc_pkg::WR_J_SI: begin
        wr_addr = j_r;
        wr_data = si_r;
      end
      rc4sc_pkg::WR_I_RD: begin
        wr_addr = i_r;
        wr_data = rd_data_r;
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = a_r;
        wr_data = rd_data_r;
      end
    endcase
  end

  // Permutation memory: one write and one registered read per cycle.
  // A read in the same cycle as a write to that entry returns the old value.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= perm_mem[rd_addr];
    end
  end

  // The final-position read saw the pre-swap memory: forward swapped entries.
  always_comb begin
    if (t_r == i_r) begin
      ks = sj_r;
    end else if (t_r == j_r) begin
      ks = si_r;
    end else begin
      ks = rd_data_r;
    end
  end

  // Captured operands and input byte.
  always_ff @(posedge clk) begin
    if (ctrl.cap_si) begin
      si_r <= rd_data_r;
    end
    if (ctrl.cap_sj) begin
      sj_r <= rd_data_r;
      t_r  <= t_addr;
    end
    if (in_fire) begin
      data_r <= in_chan.data_in;
    end
    if (ctrl.out_load && out_free) begin
      out_data_r <= data_r ^ ks;
    end
  end

  // Control state: indices, counters, keyed flag, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      a_r         <= '0;
      k_r         <= '0;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
      unique case (ctrl.a_op)
        rc4sc_pkg::A_INC_INIT: begin
          a_r <= a_r + 1'b1;
          k_r <= '0;
        end
        rc4sc_pkg::A_INC_KSA: begin
          a_r <= a_r + 1'b1;
          k_r <= k_last ? '0 : k_r + 1'b1;
        end
        default: begin
          a_r <= a_r;
          k_r <= k_r;
        end
      endcase
      if (ctrl.set_keyed) begin
        keyed_r <= 1'b1;
      end
      if (ctrl.out_load && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
